### rtl/energy_weighted_pixel_sampler_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the energy-weighted pixel sampler.
// Each macro checks a property on the rising edge of i_clk outside reset.
// ----------------------------------------------------------------------------
`ifndef ENERGY_WEIGHTED_PIXEL_SAMPLER_TOP_DEFINES_SVH
`define ENERGY_WEIGHTED_PIXEL_SAMPLER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define EWPS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ewps assertion failed");
`define EWPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ewps assertion failed");
`else
`define EWPS_ASSERT_IMP(label, ante, cons)
`define EWPS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/ewps_pkg.sv
// ----------------------------------------------------------------------------
// ewps_pkg
// Shared types and constants of the energy-weighted pixel sampler.
// ----------------------------------------------------------------------------
package ewps_pkg;

    localparam int DEF_MAX_WIDTH     = 256;
    localparam int DEF_MAX_HEIGHT    = 256;
    localparam int DEF_FRACTION_BITS = 16;

    localparam int CFG_RESET_SIZE = 256;
    localparam int CFG_DATA_W     = 9;
    localparam int COLOR_W        = 8;
    localparam int FRAC_W         = 16;
    localparam int ENERGY_W       = 24;
    localparam int INDEX_OUT_W    = 16;
    localparam int COORD_W        = 8;

    localparam logic [ENERGY_W-1:0] TOTAL_MAX = '1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    typedef struct packed {
        logic load_pixel;
        logic start_sample;
        logic clear_result;
        logic set_thr;
        logic issue_read;
        logic step;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic sample_empty;
        logic search_open;
        logic div_done;
    } t_dp_status;

endpackage

### rtl/ewps_ram.sv
// ----------------------------------------------------------------------------
// ewps_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ewps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ewps_ctrl.sv
// ----------------------------------------------------------------------------
// ewps_ctrl
// Sequencer of the sampler: accepts transactions, steps the threshold,
// binary search and division, and owns the output valid flag.
// ----------------------------------------------------------------------------
module ewps_ctrl
    import ewps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_op,
    output logic       o_in_stall,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_THR,
        S_SEARCH,
        S_CMP,
        S_DIV,
        S_OUT
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd w_cmd;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        w_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_op == OP_LOAD) begin
                        w_cmd.load_pixel = 1'b1;
                    end else if (i_status.sample_empty) begin
                        w_cmd.clear_result = 1'b1;
                        n_state            = S_OUT;
                    end else begin
                        w_cmd.start_sample = 1'b1;
                        n_state            = S_THR;
                    end
                end
            end
            S_THR: begin
                w_cmd.set_thr = 1'b1;
                n_state       = S_SEARCH;
            end
            S_SEARCH: begin
                if (i_status.search_open) begin
                    w_cmd.issue_read = 1'b1;
                    n_state          = S_CMP;
                end else begin
                    w_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_CMP: begin
                w_cmd.step = 1'b1;
                n_state    = S_SEARCH;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end else begin
                    w_cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

### rtl/ewps_datapath.sv
// ----------------------------------------------------------------------------
// ewps_datapath
// Size registers, energy accumulation, cumulative store, threshold multiply,
// binary-search pointers, restoring divider and output registers.
// ----------------------------------------------------------------------------
module ewps_datapath
    import ewps_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_write,
    input  logic                   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_first,
    input  logic [COLOR_W-1:0]     i_rend_red,
    input  logic [COLOR_W-1:0]     i_rend_green,
    input  logic [COLOR_W-1:0]     i_rend_blue,
    input  logic [COLOR_W-1:0]     i_src_red,
    input  logic [COLOR_W-1:0]     i_src_green,
    input  logic [COLOR_W-1:0]     i_src_blue,
    input  logic [FRAC_W-1:0]      i_fraction,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    output logic [INDEX_OUT_W-1:0] o_pixel_index,
    output logic [COORD_W-1:0]     o_column,
    output logic [COORD_W-1:0]     o_row,
    output logic                   o_found
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int PROD_W = FRAC_W + ENERGY_W;
    localparam int DCNT_W = $clog2(IDX_W + 1);
    localparam int RST_W  = (CFG_RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET_SIZE;
    localparam int RST_H  = (CFG_RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RESET_SIZE;
    localparam int RST_CAP = RST_W * RST_H;

    function automatic logic [12:0] clamp_size(input logic [CFG_DATA_W-1:0] v, input int hi);
        logic [12:0] res;
        if (v == '0) begin
            res = 13'd1;
        end else if (int'(v) > hi) begin
            res = 13'(hi);
        end else begin
            res = {4'b0, v};
        end
        return res;
    endfunction

    function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                    input logic [COLOR_W-1:0] b);
        logic [COLOR_W-1:0] res;
        res = (a > b) ? (a - b) : (b - a);
        return res;
    endfunction

    // Size registers and capacity.
    logic [WW-1:0]      r_width, n_width;
    logic [HW-1:0]      r_height, n_height;
    logic [CNT_W-1:0]   r_capacity;
    logic [12:0]        w_clamp_w, w_clamp_h;
    logic [WW+HW-1:0]   w_cap_full;

    assign w_clamp_w  = clamp_size(i_cfg_data, MAX_WIDTH);
    assign w_clamp_h  = clamp_size(i_cfg_data, MAX_HEIGHT);
    assign n_width    = (i_cfg_index == CFG_IDX_WIDTH) ? w_clamp_w[WW-1:0] : r_width;
    assign n_height   = (i_cfg_index == CFG_IDX_HEIGHT) ? w_clamp_h[HW-1:0] : r_height;
    assign w_cap_full = n_width * n_height;

    // Load path.
    logic [CNT_W-1:0]    r_count, w_cnt_base;
    logic [ENERGY_W-1:0] r_total, w_tot_base, w_tot_sat;
    logic [9:0]          w_energy;
    logic [ENERGY_W:0]   w_tot_sum;
    logic                w_room;
    logic                w_we;

    assign w_cnt_base = i_first ? '0 : r_count;
    assign w_tot_base = i_first ? '0 : r_total;
    assign w_energy   = {2'b0, abs_diff(i_rend_red, i_src_red)}
                      + {2'b0, abs_diff(i_rend_green, i_src_green)}
                      + {2'b0, abs_diff(i_rend_blue, i_src_blue)};
    assign w_tot_sum  = {1'b0, w_tot_base} + {15'b0, w_energy};
    assign w_tot_sat  = w_tot_sum[ENERGY_W] ? TOTAL_MAX : w_tot_sum[ENERGY_W-1:0];
    assign w_room     = (w_cnt_base < r_capacity);
    assign w_we       = i_cmd.load_pixel && w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WW'(RST_W);
            r_height   <= HW'(RST_H);
            r_capacity <= CNT_W'(RST_CAP);
            r_count    <= '0;
            r_total    <= '0;
        end else begin
            if (i_cfg_write) begin
                r_width    <= n_width;
                r_height   <= n_height;
                r_capacity <= w_cap_full[CNT_W-1:0];
            end
            if (i_cmd.load_pixel) begin
                if (w_room) begin
                    r_count <= w_cnt_base + 1'b1;
                    r_total <= w_tot_sat;
                end else begin
                    r_count <= w_cnt_base;
                    r_total <= w_tot_base;
                end
            end
        end
    end

    // Threshold and binary search.
    logic [PROD_W-1:0]   r_prod;
    logic [PROD_W-1:0]   w_prod_shift;
    logic [ENERGY_W-1:0] r_thr, w_thr;
    logic [IDX_W-1:0]    r_lo, r_hi, r_mid, w_mid, w_span;
    logic [CNT_W-1:0]    w_last;
    logic [ENERGY_W-1:0] w_rd_data;
    logic                r_found;

    assign w_prod_shift = r_prod >> FRACTION_BITS;
    assign w_thr        = (w_prod_shift > {{FRAC_W{1'b0}}, r_total}) ? r_total
                                                                   : w_prod_shift[ENERGY_W-1:0];
    assign w_span       = r_hi - r_lo;
    assign w_mid        = r_lo + (w_span >> 1);
    assign w_last       = r_count - 1'b1;

    ewps_ram #(
        .WIDTH (ENERGY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_cnt_base[IDX_W-1:0]),
        .i_wdata (w_tot_sat),
        .i_re    (i_cmd.issue_read),
        .i_raddr (w_mid),
        .o_rdata (w_rd_data)
    );

    // Restoring divider: index divided by the effective height.
    logic [IDX_W-1:0]  r_quot;
    logic [HW-1:0]     r_rem;
    logic [DCNT_W-1:0] r_div_cnt;
    logic [HW:0]       w_rem_shift;
    logic              w_rem_ge;

    assign w_rem_shift = {r_rem, r_quot[IDX_W-1]};
    assign w_rem_ge    = (w_rem_shift >= {1'b0, r_height});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else begin
            if (i_cmd.div_start) begin
                r_div_cnt <= DCNT_W'(IDX_W);
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_sample) begin
            r_prod  <= i_fraction * r_total;
            r_lo    <= '0;
            r_hi    <= w_last[IDX_W-1:0];
            r_found <= 1'b1;
        end
        if (i_cmd.clear_result) begin
            r_lo    <= '0;
            r_quot  <= '0;
            r_rem   <= '0;
            r_found <= 1'b0;
        end
        if (i_cmd.set_thr) begin
            r_thr <= w_thr;
        end
        if (i_cmd.issue_read) begin
            r_mid <= w_mid;
        end
        if (i_cmd.step) begin
            if (w_rd_data >= r_thr) begin
                r_hi <= r_mid;
            end else begin
                r_lo <= r_mid + 1'b1;
            end
        end
        if (i_cmd.div_start) begin
            r_quot <= r_lo;
            r_rem  <= '0;
        end
        if (i_cmd.div_step) begin
            r_quot <= {r_quot[IDX_W-2:0], w_rem_ge};
            r_rem  <= w_rem_ge ? HW'(w_rem_shift - {1'b0, r_height}) : w_rem_shift[HW-1:0];
        end
    end

    // Output registers.
    logic [IDX_W+INDEX_OUT_W-1:0] w_lo_ext;
    logic [IDX_W+COORD_W-1:0]     w_quot_ext;
    logic [HW+COORD_W-1:0]        w_rem_ext;
    logic [INDEX_OUT_W-1:0]       r_out_index;
    logic [COORD_W-1:0]           r_out_column;
    logic [COORD_W-1:0]           r_out_row;
    logic                         r_out_found;

    assign w_lo_ext   = {{INDEX_OUT_W{1'b0}}, r_lo};
    assign w_quot_ext = {{COORD_W{1'b0}}, r_quot};
    assign w_rem_ext  = {{COORD_W{1'b0}}, r_rem};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_index  <= w_lo_ext[INDEX_OUT_W-1:0];
            r_out_column <= w_quot_ext[COORD_W-1:0];
            r_out_row    <= w_rem_ext[COORD_W-1:0];
            r_out_found  <= r_found;
        end
    end

    assign o_status.sample_empty = (r_count == '0) || (r_total == '0);
    assign o_status.search_open  = (r_lo < r_hi);
    assign o_status.div_done     = (r_div_cnt == '0);

    assign o_pixel_index = r_out_index;
    assign o_column      = r_out_column;
    assign o_row         = r_out_row;
    assign o_found       = r_out_found;

endmodule

### rtl/energy_weighted_pixel_sampler_top.sv
// ----------------------------------------------------------------------------
// Energy-weighted pixel sampler, top level.
// Loads may follow each other in every cycle. A sample transaction stalls the
// input until its result is registered: it sets the threshold, runs at most
// ceil(log2(loaded pixels)) binary-search steps, then divides the found index
// by the effective height to get the column and row. Each search step issues a
// registered read of the cumulative store and then compares the read value
// with the threshold. The restoring divider yields one quotient bit per cycle
// over the index width clog2(MAX_WIDTH * MAX_HEIGHT), 16 by default.
// A sample on an empty frame or on a frame of zero energy skips the search and
// the division, and every sample waits in its output state while an earlier
// result is held by a stalled output.
// ----------------------------------------------------------------------------
`include "energy_weighted_pixel_sampler_top_defines.svh"

module energy_weighted_pixel_sampler_top
    import ewps_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_in_op,
    input  logic                   i_in_first,
    input  logic [COLOR_W-1:0]     i_in_rend_red,
    input  logic [COLOR_W-1:0]     i_in_rend_green,
    input  logic [COLOR_W-1:0]     i_in_rend_blue,
    input  logic [COLOR_W-1:0]     i_in_src_red,
    input  logic [COLOR_W-1:0]     i_in_src_green,
    input  logic [COLOR_W-1:0]     i_in_src_blue,
    input  logic [FRAC_W-1:0]      i_in_fraction,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [INDEX_OUT_W-1:0] o_out_pixel_index,
    output logic [COORD_W-1:0]     o_out_column,
    output logic [COORD_W-1:0]     o_out_row,
    output logic                   o_out_found
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_cfg_write;
    logic       w_in_accept;
    logic       w_out_zero;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_zero  = (o_out_pixel_index == '0) && (o_out_column == '0) && (o_out_row == '0);

    ewps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_in_op),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    ewps_datapath #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_write   (w_cfg_write),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_first       (i_in_first),
        .i_rend_red    (i_in_rend_red),
        .i_rend_green  (i_in_rend_green),
        .i_rend_blue   (i_in_rend_blue),
        .i_src_red     (i_in_src_red),
        .i_src_green   (i_in_src_green),
        .i_src_blue    (i_in_src_blue),
        .i_fraction    (i_in_fraction),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_pixel_index (o_out_pixel_index),
        .o_column      (o_out_column),
        .o_row         (o_out_row),
        .o_found       (o_out_found)
    );

    `EWPS_ASSERT_NEXT(a_sample_holds_input, w_in_accept && (i_in_op == OP_SAMPLE), o_in_stall)
    `EWPS_ASSERT_IMP(a_not_found_zero, o_out_valid && !o_out_found, w_out_zero)
    `EWPS_ASSERT_NEXT(a_read_then_step, w_cmd.issue_read, w_cmd.step)
    `EWPS_ASSERT_IMP(a_load_no_stall, w_cmd.load_pixel, w_in_accept && (i_in_op == OP_LOAD))

endmodule

### test/pixel_pick_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel pick checker
// Watches the configuration, input and result channels of the energy-weighted
// pixel sampler. It keeps its own copy of the frame energies and of the size
// registers, works out the pick that each sample transaction must return, and
// compares every accepted result with the oldest pick still awaited.
// ----------------------------------------------------------------------------
module pixel_pick_checker
    import ewps_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic                   i_in_op,
    input  logic                   i_in_first,
    input  logic [COLOR_W-1:0]     i_in_rend_red,
    input  logic [COLOR_W-1:0]     i_in_rend_green,
    input  logic [COLOR_W-1:0]     i_in_rend_blue,
    input  logic [COLOR_W-1:0]     i_in_src_red,
    input  logic [COLOR_W-1:0]     i_in_src_green,
    input  logic [COLOR_W-1:0]     i_in_src_blue,
    input  logic [FRAC_W-1:0]      i_in_fraction,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [INDEX_OUT_W-1:0] i_out_pixel_index,
    input  logic [COORD_W-1:0]     i_out_column,
    input  logic [COORD_W-1:0]     i_out_row,
    input  logic                   i_out_found,
    output int                     o_failures,
    output int                     o_pending
);

    localparam int STORE_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

    typedef struct packed {
        logic [INDEX_OUT_W-1:0] pixel_index;
        logic [COORD_W-1:0]     column;
        logic [COORD_W-1:0]     row;
        logic                   found;
    } pick_t;

    logic [ENERGY_W-1:0]   cum_energy [STORE_DEPTH];
    logic [ENERGY_W-1:0]   frame_energy;
    logic [16:0]           pixels_loaded;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    pick_t                 expected_picks[$];
    int                    failures = 0;
    int                    backlog = 0;

    assign o_failures = failures;
    assign o_pending  = backlog;

    function automatic logic [31:0] clamp_dim(input logic [CFG_DATA_W-1:0] v, input int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                    input logic [COLOR_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    always @(posedge i_clk) begin : track
        pick_t                      want;
        pick_t                      got;
        logic [31:0]                cap;
        logic [31:0]                h;
        logic [31:0]                lo;
        logic [31:0]                hi;
        logic [31:0]                mid;
        logic [31:0]                col;
        logic [31:0]                row;
        logic [ENERGY_W:0]          sum;
        logic [FRAC_W+ENERGY_W-1:0] thr;
        if (!i_rst_n) begin
            frame_energy  = '0;
            pixels_loaded = '0;
            width_reg     = CFG_DATA_W'(CFG_RESET_SIZE);
            height_reg    = CFG_DATA_W'(CFG_RESET_SIZE);
            expected_picks.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_out_pixel_index, i_out_column, i_out_row, i_out_found};
                if (expected_picks.size() == 0) begin
                    failures++;
                    if (failures <= 10) begin
                        $display("unexpected result: index %0d column %0d row %0d found %0b",
                                 got.pixel_index, got.column, got.row, got.found);
                    end
                end else begin
                    want = expected_picks.pop_front();
                    if (want.pixel_index !== got.pixel_index || want.column !== got.column ||
                        want.row !== got.row || want.found !== got.found) begin
                        failures++;
                        if (failures <= 10) begin
                            $display("pick mismatch: expected index %0d column %0d row %0d %s",
                                     want.pixel_index, want.column, want.row,
                                     want.found ? "found" : "not found");
                            $display("               actual   index %0d column %0d row %0d %s",
                                     got.pixel_index, got.column, got.row,
                                     got.found === 1'b1 ? "found" : "not found");
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_IDX_WIDTH) begin
                    width_reg = i_cfg_data;
                end else if (i_cfg_index == CFG_IDX_HEIGHT) begin
                    height_reg = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                h   = clamp_dim(height_reg, DEF_MAX_HEIGHT);
                cap = clamp_dim(width_reg, DEF_MAX_WIDTH) * h;
                if (i_in_op == OP_LOAD) begin
                    if (i_in_first) begin
                        pixels_loaded = '0;
                        frame_energy  = '0;
                    end
                    if (pixels_loaded < cap) begin
                        sum = frame_energy + abs_diff(i_in_rend_red, i_in_src_red)
                            + abs_diff(i_in_rend_green, i_in_src_green)
                            + abs_diff(i_in_rend_blue, i_in_src_blue);
                        frame_energy = sum[ENERGY_W] ? TOTAL_MAX : sum[ENERGY_W-1:0];
                        cum_energy[pixels_loaded[15:0]] = frame_energy;
                        pixels_loaded = pixels_loaded + 1'b1;
                    end
                end else begin
                    want = '0;
                    if (pixels_loaded != 0 && frame_energy != 0) begin
                        thr = (i_in_fraction * frame_energy) >> DEF_FRACTION_BITS;
                        if (thr > frame_energy) thr = frame_energy;
                        lo = 0;
                        hi = pixels_loaded - 1;
                        while (lo < hi) begin
                            mid = lo + ((hi - lo) >> 1);
                            if (cum_energy[mid[15:0]] >= thr) hi = mid;
                            else lo = mid + 1;
                        end
                        col = lo / h;
                        row = lo % h;
                        want.pixel_index = lo[INDEX_OUT_W-1:0];
                        want.column      = col[COORD_W-1:0];
                        want.row         = row[COORD_W-1:0];
                        want.found       = 1'b1;
                    end
                    expected_picks.insert(expected_picks.size(), want);
                end
            end
        end
        backlog = expected_picks.size();
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Energy-weighted pixel sampler testbench
// Drives pixel loads and sample transactions with random gaps and result
// stalls, walks the frame size through its extremes, loads a short frame at the
// largest size setting, and gives the verdict from the failure count of the
// pixel pick checker.
// ----------------------------------------------------------------------------
module testbench;
    import ewps_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 64;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic                   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_in_op;
    logic                   i_in_first;
    logic [COLOR_W-1:0]     i_in_rend_red;
    logic [COLOR_W-1:0]     i_in_rend_green;
    logic [COLOR_W-1:0]     i_in_rend_blue;
    logic [COLOR_W-1:0]     i_in_src_red;
    logic [COLOR_W-1:0]     i_in_src_green;
    logic [COLOR_W-1:0]     i_in_src_blue;
    logic [FRAC_W-1:0]      i_in_fraction;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [INDEX_OUT_W-1:0] o_out_pixel_index;
    logic [COORD_W-1:0]     o_out_column;
    logic [COORD_W-1:0]     o_out_row;
    logic                   o_out_found;

    int failures;
    int pending;
    int cycle_count = 0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;

    energy_weighted_pixel_sampler_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_in_op           (i_in_op),
        .i_in_first        (i_in_first),
        .i_in_rend_red     (i_in_rend_red),
        .i_in_rend_green   (i_in_rend_green),
        .i_in_rend_blue    (i_in_rend_blue),
        .i_in_src_red      (i_in_src_red),
        .i_in_src_green    (i_in_src_green),
        .i_in_src_blue     (i_in_src_blue),
        .i_in_fraction     (i_in_fraction),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_pixel_index (o_out_pixel_index),
        .o_out_column      (o_out_column),
        .o_out_row         (o_out_row),
        .o_out_found       (o_out_found)
    );

    pixel_pick_checker pick_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_in_op           (i_in_op),
        .i_in_first        (i_in_first),
        .i_in_rend_red     (i_in_rend_red),
        .i_in_rend_green   (i_in_rend_green),
        .i_in_rend_blue    (i_in_rend_blue),
        .i_in_src_red      (i_in_src_red),
        .i_in_src_green    (i_in_src_green),
        .i_in_src_blue     (i_in_src_blue),
        .i_in_fraction     (i_in_fraction),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_out_pixel_index (o_out_pixel_index),
        .i_out_column      (o_out_column),
        .i_out_row         (o_out_row),
        .i_out_found       (o_out_found),
        .o_failures        (failures),
        .o_pending         (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : result_stall
        int hold;
        i_out_stall = 1'b0;
        @(negedge i_clk);
        forever begin
            hold = rx_quiet ? 0 : $urandom_range(0, 17);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                do @(posedge i_clk); while (!o_out_valid);
                repeat (hold - 1) @(posedge i_clk);
                @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    function automatic logic [FRAC_W-1:0] draw_fraction();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return FRAC_W'($urandom);
        endcase
    endfunction

    task automatic send(input logic op, input logic first, input logic [23:0] rend,
                        input logic [23:0] src, input logic [FRAC_W-1:0] frac);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_op    <= op;
        i_in_first <= first;
        {i_in_rend_red, i_in_rend_green, i_in_rend_blue} <= rend;
        {i_in_src_red, i_in_src_green, i_in_src_blue}    <= src;
        i_in_fraction <= frac;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic send_load(input logic first, input logic [23:0] rend, input logic [23:0] src);
        send(OP_LOAD, first, rend, src, FRAC_W'($urandom));
    endtask

    task automatic send_sample(input logic [FRAC_W-1:0] frac);
        send(OP_SAMPLE, 1'($urandom_range(0, 1)), 24'($urandom), 24'($urandom), frac);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_IDX_WIDTH;
        i_cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_index <= CFG_IDX_HEIGHT;
        i_cfg_data  <= h;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned w;
        int unsigned h;
        int unsigned cap;
        int unsigned frame_len;
        int unsigned style;
        int unsigned items;
        int unsigned n;
        logic [23:0] rend;
        logic [23:0] src;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_IDX_WIDTH;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_in_op         = OP_LOAD;
        i_in_first      = 1'b0;
        i_in_rend_red   = '0;
        i_in_rend_green = '0;
        i_in_rend_blue  = '0;
        i_in_src_red    = '0;
        i_in_src_green  = '0;
        i_in_src_blue   = '0;
        i_in_fraction   = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_sample('1);
        send_load(1'b1, 24'h000000, 24'h000000);
        send_load(1'b0, 24'hFFFFFF, 24'hFFFFFF);
        send_sample(16'h8000);
        send_load(1'b0, 24'hFFFFFF, 24'h000000);
        send_load(1'b0, 24'h000000, 24'hFFFFFF);
        send_load(1'b0, 24'h807F01, 24'h7F80FE);
        send_sample('0);
        send_sample('1);
        send_sample(16'h8000);
        send_sample(16'h4000);

        settle();
        set_size(9'd2, 9'd3);
        send_load(1'b1, 24'($urandom), 24'($urandom));
        repeat (7) send_load(1'b0, 24'($urandom), 24'($urandom));
        send_sample('1);
        send_sample(FRAC_W'($urandom));
        send_load(1'b1, 24'hFFFFFF, 24'h000000);
        send_sample('0);

        settle();
        set_size(9'd0, 9'd0);
        send_load(1'b1, 24'h102030, 24'h010203);
        send_load(1'b0, 24'hFFFFFF, 24'h000000);
        send_sample('1);

        // A short high-energy frame at the largest size setting, sampled at both ends and at random.
        settle();
        set_size(9'd511, 9'd256);
        tx_quiet = 1'b1;
        for (n = 0; n < 64; n++) begin
            rend = 24'($urandom);
            src  = (n % 8 == 7) ? rend : ~rend;
            send_load(n == 0, rend, src);
        end
        tx_quiet = 1'b0;
        send_sample('0);
        send_sample('1);
        repeat (8) send_sample(FRAC_W'($urandom));
        settle();
        set_size(9'd256, 9'd1);
        repeat (4) send_sample(draw_fraction());
        settle();
        set_size(9'd256, 9'd7);
        repeat (4) send_sample(draw_fraction());

        for (int phase = 0; phase < 12; phase++) begin
            settle();
            case ($urandom_range(0, 9))
                0:       w = 0;
                1:       w = $urandom_range(257, 511);
                default: w = $urandom_range(1, 12);
            endcase
            case ($urandom_range(0, 9))
                0:       h = 0;
                1:       h = $urandom_range(257, 511);
                default: h = $urandom_range(1, 12);
            endcase
            set_size(CFG_DATA_W'(w), CFG_DATA_W'(h));
            cap = (w == 0 ? 1 : (w > 256 ? 256 : w)) * (h == 0 ? 1 : (h > 256 ? 256 : h));
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            items = 0;
            while (items < 100) begin
                style     = $urandom_range(0, 4);
                frame_len = $urandom_range(1, (cap + 3 < 40) ? cap + 3 : 40);
                for (int k = 0; k < frame_len; k++) begin
                    rend = 24'($urandom);
                    case (style)
                        0:       src = rend;
                        1, 2:    src = 24'($urandom);
                        3:       src = ($urandom_range(0, 5) == 0) ? 24'($urandom) : rend;
                        default: src = ~rend;
                    endcase
                    send_load((k == 0) ? ($urandom_range(0, 5) != 0)
                                       : ($urandom_range(0, 49) == 0), rend, src);
                    items++;
                    if ($urandom_range(0, 2) == 0) begin
                        send_sample(draw_fraction());
                        items++;
                    end
                end
                repeat ($urandom_range(1, 3)) begin
                    send_sample(draw_fraction());
                    items++;
                end
            end
        end

        settle();
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### energy_weighted_pixel_sampler_top.f
+incdir+rtl
rtl/ewps_pkg.sv
rtl/ewps_ram.sv
rtl/ewps_ctrl.sv
rtl/ewps_datapath.sv
rtl/energy_weighted_pixel_sampler_top.sv
test/pixel_pick_checker.sv
test/testbench.sv
